// ===== hw/rtl/ikvt_pkg.sv =====
`default_nettype none

package ikvt_pkg;

	// Default table depth
	localparam int unsigned ENTRIES_DEF = 64;

	// Request payload widths
	localparam int unsigned KIND_W = 2;
	localparam int unsigned WORD_W = 32;
	// Stored key drops the sign bit
	localparam int unsigned SKEY_W = WORD_W - 1;
	// Reported slot carries the low bits of the index
	localparam int unsigned SLOT_W = 6;

	typedef enum logic [KIND_W-1:0] {
		REQ_SET    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADKEY = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_CLEAR,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ikvt_req_if.sv =====
`default_nettype none

// Request channel
interface ikvt_req_if;
	logic                               valid;
	logic                               ready;
	logic [ikvt_pkg::KIND_W-1:0]        req_type;
	logic signed [ikvt_pkg::WORD_W-1:0] key;
	logic signed [ikvt_pkg::WORD_W-1:0] data_in;

	modport source (output valid, req_type, key, data_in, input ready);
	modport sink   (input valid, req_type, key, data_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ikvt_rsp_if.sv =====
`default_nettype none

// Response channel
interface ikvt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               found;
	logic signed [ikvt_pkg::WORD_W-1:0] data_out;
	logic [ikvt_pkg::SLOT_W-1:0]        slot;
	ikvt_pkg::status_t                  status;

	modport source (output valid, found, data_out, slot, status, input ready);
	modport sink   (input valid, found, data_out, slot, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/int_key_value_table.sv =====
`default_nettype none

// Associative table of ENTRIES integer key/value pairs, searched one slot per
// clock through a single compare unit reading the key and value memories.
// For set, lookup and delete the request is accepted, the read pipeline fills,
// slots are compared in order until a match or the last slot, and the response
// is posted; a lookup that matches early returns early. A request with a
// negative key skips the scan; a set with one answers ST_BADKEY. Clear walks
// the key memory one slot per cycle. After reset the block clears the key
// memory before it takes the first request. One request is in work at a time;
// a response waits in an output register until taken.
module int_key_value_table #(
	parameter int unsigned ENTRIES = ikvt_pkg::ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	ikvt_req_if.sink    req,
	ikvt_rsp_if.source  rsp
);
	import ikvt_pkg::*;

	localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNTW = IDXW + 1;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);
	localparam logic [CNTW-1:0] CNT_END  = CNTW'(ENTRIES);

	// Memories: key memory holds {valid, key}
	logic [WORD_W-1:0] kmem [ENTRIES];
	logic [WORD_W-1:0] vmem [ENTRIES];

	state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q;
	logic [IDXW-1:0] raddr;

	// Latched request
	req_kind_t          kind_q;
	logic [SKEY_W-1:0]  key_q;
	logic [WORD_W-1:0]  data_q;

	// Read pipeline
	logic              rd_issue;
	logic              rd_vld_s1;
	logic [IDXW-1:0]   rd_idx_s1;
	logic [WORD_W-1:0] kmem_rd_s1;
	logic [WORD_W-1:0] vmem_rd_s1;

	// Lowest free slot seen so far
	logic            free_found_q;
	logic [IDXW-1:0] free_idx_q;

	// Staged result
	logic              res_found_q, res_found_d;
	logic [WORD_W-1:0] res_data_q, res_data_d;
	logic [IDXW-1:0]   res_slot_q, res_slot_d;
	status_t           res_status_q, res_status_d;
	logic              res_load;

	// Output register
	logic              rsp_valid_q;
	logic              rsp_found_q;
	logic [WORD_W-1:0] rsp_data_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	status_t           rsp_status_q;
	logic [IDXW+SLOT_W-1:0] slot_ext;

	// Memory write controls
	logic              kwe, vwe;
	logic [IDXW-1:0]   kwa, vwa;
	logic [WORD_W-1:0] kwd, vwd;

	logic      accept;
	req_kind_t in_kind;
	logic      in_neg;
	logic      entry_valid, entry_hit, entry_free, scan_last, scan_done;
	logic      free_avail;
	logic [IDXW-1:0] free_idx_now;
	logic      rsp_free;

	assign accept   = req.valid && req.ready;
	assign in_kind  = req_kind_t'(req.req_type);
	assign in_neg   = req.key[WORD_W-1];
	assign raddr    = cnt_q[IDXW-1:0];
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// Compare unit on the registered read data
	assign entry_valid  = kmem_rd_s1[WORD_W-1];
	assign entry_hit    = rd_vld_s1 && entry_valid && (kmem_rd_s1[SKEY_W-1:0] == key_q);
	assign entry_free   = rd_vld_s1 && !entry_valid;
	assign scan_last    = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
	assign scan_done    = entry_hit || scan_last;
	assign free_avail   = free_found_q || entry_free;
	assign free_idx_now = free_found_q ? free_idx_q : rd_idx_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (raddr == LAST_IDX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (in_kind == REQ_CLEAR) state_d = S_CLEAR;
					else if (in_neg) state_d = S_DONE;
					else state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) state_d = S_DONE;
			end
			S_CLEAR: begin
				if (raddr == LAST_IDX) state_d = S_DONE;
			end
			S_DONE: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: handshake, memory writes, result staging
	always_comb begin
		req.ready    = (state_q == S_IDLE);
		rd_issue     = (state_q == S_SCAN) && (cnt_q < CNT_END);
		kwe          = 1'b0;
		kwa          = raddr;
		kwd          = '0;
		vwe          = 1'b0;
		vwa          = rd_idx_s1;
		vwd          = data_q;
		res_load     = 1'b0;
		res_found_d  = 1'b0;
		res_data_d   = '0;
		res_slot_d   = '0;
		res_status_d = ST_OK;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				kwe = 1'b1;
			end
			S_IDLE: begin
				res_load = accept;
				if (in_kind == REQ_SET && in_neg) res_status_d = ST_BADKEY;
			end
			S_SCAN: begin
				if (scan_done) begin
					res_load = 1'b1;
					if (entry_hit) begin
						res_found_d = 1'b1;
						res_slot_d  = rd_idx_s1;
						if (kind_q == REQ_LOOKUP) res_data_d = vmem_rd_s1;
					end
					unique case (kind_q)
						REQ_SET: begin
							if (entry_hit) begin
								vwe = 1'b1;
							end else if (free_avail) begin
								kwe        = 1'b1;
								kwa        = free_idx_now;
								kwd        = {1'b1, key_q};
								vwe        = 1'b1;
								vwa        = free_idx_now;
								res_slot_d = free_idx_now;
							end else begin
								res_status_d = ST_FULL;
							end
						end
						REQ_DELETE: begin
							if (entry_hit) begin
								kwe = 1'b1;
								kwa = rd_idx_s1;
								kwd = {1'b0, key_q};
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Key and value memories, registered read
	always_ff @(posedge clk) begin
		if (kwe) kmem[kwa] <= kwd;
		kmem_rd_s1 <= kmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (vwe) vmem[vwa] <= vwd;
		vmem_rd_s1 <= vmem[raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (accept) begin
				cnt_q        <= '0;
				free_found_q <= 1'b0;
			end else if (state_q == S_INIT || state_q == S_CLEAR || rd_issue) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			if (state_q == S_SCAN && entry_free && !free_found_q) free_found_q <= 1'b1;
			if (state_q == S_DONE && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, res_slot_q};

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
		if (accept) begin
			kind_q <= in_kind;
			key_q  <= req.key[SKEY_W-1:0];
			data_q <= req.data_in;
		end
		if (state_q == S_SCAN && entry_free && !free_found_q) free_idx_q <= rd_idx_s1;
		if (res_load) begin
			res_found_q  <= res_found_d;
			res_data_q   <= res_data_d;
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_found_q  <= res_found_q;
			rsp_data_q   <= res_data_q;
			rsp_slot_q   <= slot_ext[SLOT_W-1:0];
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = rsp_found_q;
	assign rsp.data_out = rsp_data_q;
	assign rsp.slot     = rsp_slot_q;
	assign rsp.status   = rsp_status_q;

endmodule

`default_nettype wire
